// ===== rtl/etss_pkg.sv =====
package etss_pkg;

  localparam int MS_W = 31;
  localparam int TENTHS_W = 25;
  localparam int SEG_W = 8;
  localparam int POS_OUT_W = 2;
  localparam int POINT_POSITION = 1;

  localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
  localparam int DIV100_SHIFT = 37;
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;

  localparam logic [SEG_W-1:0] POINT_BIT = 8'h80;

  typedef logic [TENTHS_W-1:0] tenths_t;
  typedef logic [SEG_W-1:0] seg_t;

  function automatic tenths_t div100(input logic [MS_W-1:0] ms);
    logic [63:0] prod;
    prod = 64'(ms) * 64'(DIV100_MAGIC);
    return prod[DIV100_SHIFT +: TENTHS_W];
  endfunction

  function automatic tenths_t div10(input tenths_t v);
    logic [63:0] prod;
    prod = 64'(v) * 64'(DIV10_MAGIC);
    return prod[DIV10_SHIFT +: TENTHS_W];
  endfunction

  // common-cathode map, inverted for active-low anode drive
  function automatic seg_t seg_encode(input logic [3:0] digit, input logic point);
    seg_t cc;
    unique case (digit)
      4'd0: cc = 8'h3f;
      4'd1: cc = 8'h06;
      4'd2: cc = 8'h5b;
      4'd3: cc = 8'h4f;
      4'd4: cc = 8'h66;
      4'd5: cc = 8'h6d;
      4'd6: cc = 8'h7d;
      4'd7: cc = 8'h07;
      4'd8: cc = 8'h7f;
      4'd9: cc = 8'h6f;
      default: cc = 8'h00;
    endcase
    if (point) begin
      cc = cc | POINT_BIT;
    end
    return ~cc;
  endfunction

endpackage

// ===== rtl/elapsed_time_seven_segment_scan.sv =====
// Elapsed-time scan driver: each transaction on in_ carries a time in milliseconds; the block
// divides it by 100 and emits DIGIT_COUNT active-low segment frames on out_, tenths first,
// with the decimal point lit on position 1 and leading zeros shown (wraps modulo
// 10^DIGIT_COUNT tenths). The single output channel delivers one frame per cycle while out_stall
// stays low, and the pipeline can take new times while an earlier scan is still being sent. Each
// time passes through the input register (loaded by the accepting edge), the divide-by-100
// multiply, a leading divide-by-10 stage, one digit stage per digit and the frame register
// before its first frame is offered. Stalls back up through the pipeline without loss.
module elapsed_time_seven_segment_scan #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [etss_pkg::MS_W-1:0]            in_elapsed_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [etss_pkg::POS_OUT_W-1:0]       out_digit_position,
  output logic [etss_pkg::SEG_W-1:0]           out_segment_byte,
  output logic                                 out_last_digit
);

  localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_COUNT - 1);

  // input stage
  logic                          vin_r;
  logic [etss_pkg::MS_W-1:0]     ms_r;
  logic                          rdy_in;

  // tenths stage
  logic                          vt_r;
  etss_pkg::tenths_t             tenths_r;
  logic                          rdy_t;

  // digit stages
  logic [DIGIT_COUNT:0]          ve_r;
  logic [DIGIT_COUNT:0]          rdy_e;
  etss_pkg::tenths_t             prev_r [0:DIGIT_COUNT-1];
  etss_pkg::tenths_t             cur_r  [0:DIGIT_COUNT-1];
  logic [DIGIT_COUNT-1:0][etss_pkg::SEG_W-1:0] segs_r [0:DIGIT_COUNT];

  // frame serialiser
  logic                          busy_r;
  logic [POS_W-1:0]              pos_r;
  logic [DIGIT_COUNT-1:0][etss_pkg::SEG_W-1:0] frames_r;
  logic                          last;
  logic                          ser_rdy;

  assign last    = (pos_r == LAST_POS);
  assign ser_rdy = !busy_r || (!out_stall && last);

  assign rdy_in   = !vin_r || rdy_t;
  assign rdy_t    = !vt_r || rdy_e[0];
  assign in_stall = !rdy_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vin_r <= 1'b0;
    end else if (rdy_in) begin
      vin_r <= in_valid;
    end
    if (rdy_in && in_valid) begin
      ms_r <= in_elapsed_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else if (rdy_t) begin
      vt_r <= vin_r;
    end
    if (rdy_t && vin_r) begin
      tenths_r <= etss_pkg::div100(ms_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r[0] <= 1'b0;
    end else if (rdy_e[0]) begin
      ve_r[0] <= vt_r;
    end
    if (rdy_e[0] && vt_r) begin
      prev_r[0] <= tenths_r;
      cur_r[0]  <= etss_pkg::div10(tenths_r);
      segs_r[0] <= '0;
    end
  end

  genvar s;
  generate
    for (s = 1; s <= DIGIT_COUNT; s++) begin : g_digit
      logic [3:0] rem;
      logic [DIGIT_COUNT-1:0][etss_pkg::SEG_W-1:0] segs_nxt;

      always_comb begin
        rem = 4'(prev_r[s-1] - ((cur_r[s-1] << 3) + (cur_r[s-1] << 1)));
        segs_nxt = segs_r[s-1];
        segs_nxt[s-1] = etss_pkg::seg_encode(rem,
                                             (s - 1) == etss_pkg::POINT_POSITION);
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ve_r[s] <= 1'b0;
        end else if (rdy_e[s]) begin
          ve_r[s] <= ve_r[s-1];
        end
        if (rdy_e[s] && ve_r[s-1]) begin
          segs_r[s] <= segs_nxt;
        end
      end

      if (s < DIGIT_COUNT) begin : g_div
        always_ff @(posedge clk) begin
          if (rdy_e[s] && ve_r[s-1]) begin
            prev_r[s] <= cur_r[s-1];
            cur_r[s]  <= etss_pkg::div10(cur_r[s-1]);
          end
        end
      end

      assign rdy_e[s-1] = !ve_r[s-1] || rdy_e[s];
    end
  endgenerate

  assign rdy_e[DIGIT_COUNT] = !ve_r[DIGIT_COUNT] || ser_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else if (ser_rdy) begin
      busy_r <= ve_r[DIGIT_COUNT];
      pos_r  <= '0;
    end else if (!out_stall) begin
      pos_r <= POS_W'(pos_r + 1'b1);
    end
    if (ser_rdy && ve_r[DIGIT_COUNT]) begin
      frames_r <= segs_r[DIGIT_COUNT];
    end
  end

  assign out_valid          = busy_r;
  assign out_digit_position = 2'(pos_r);
  assign out_segment_byte   = frames_r[pos_r];
  assign out_last_digit     = last;

  // a scan, once started, runs without gaps to its last frame
  a_scan_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_digit |=> out_valid)
    else $error("scan broke off before its last frame");

  a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_digit |=>
      out_digit_position == 2'($past(out_digit_position) + 2'd1))
    else $error("digit position did not advance by one");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule
